/* design/rbd_pkg.sv */
// shared types and constants for the rgba box downscaler
package rbd_pkg;

    // field and datapath widths
    localparam int CH_W   = 8;
    localparam int SRC_CW = 14;
    localparam int LIM_CW = 13;
    localparam int RES_W  = 13;
    localparam int DIM_W  = 15;
    localparam int SUM_W  = 34;
    localparam int CNT_W  = 26;
    localparam int IDX_W  = 8;

    // register indexes
    localparam logic [IDX_W-1:0] REG_SRC_W = 8'd0;
    localparam logic [IDX_W-1:0] REG_SRC_H = 8'd1;
    localparam logic [IDX_W-1:0] REG_LIM_W = 8'd2;
    localparam logic [IDX_W-1:0] REG_LIM_H = 8'd3;

    // reset values of the registers
    localparam logic [SRC_CW-1:0] RST_SRC_W = 14'd1;
    localparam logic [SRC_CW-1:0] RST_SRC_H = 14'd1;
    localparam logic [LIM_CW-1:0] RST_LIM_W = 13'd3840;
    localparam logic [LIM_CW-1:0] RST_LIM_H = 13'd2560;

    // parameter defaults
    localparam int DEF_MAX_OUT_WIDTH = 4096;
    localparam int DEF_MAX_SRC_DIM   = 8192;

    // one column accumulator word
    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] alpha;
        logic [CNT_W-1:0] count;
    } acc_t;

endpackage

/* design/rgba_box_downscaler_core.sv */
// Pixel processing: a source pixel without a result passes accept, memory read and
// write back; a pixel that closes a box adds bit-serial division (one quotient bit
// per cycle, four channels in parallel) and a load into the output register once it is free.
// A register write to a known index, and reset, start a scale recompute (two 15-step
// serial divides) during which no pixel or register write is taken.
// Reset is synchronous active low; column accumulator memory is not cleared.
module rgba_box_downscaler_core #(
    parameter int MAX_OUT_WIDTH = rbd_pkg::DEF_MAX_OUT_WIDTH,
    parameter int MAX_SRC_DIM   = rbd_pkg::DEF_MAX_SRC_DIM
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rbd_pkg::IDX_W-1:0]    cfg_index,
    input  logic [rbd_pkg::SRC_CW-1:0]   cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [rbd_pkg::CH_W-1:0]     s_pix_red,
    input  logic [rbd_pkg::CH_W-1:0]     s_pix_green,
    input  logic [rbd_pkg::CH_W-1:0]     s_pix_blue,
    input  logic [rbd_pkg::CH_W-1:0]     s_pix_alpha,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [rbd_pkg::CH_W-1:0]     m_avg_red,
    output logic [rbd_pkg::CH_W-1:0]     m_avg_green,
    output logic [rbd_pkg::CH_W-1:0]     m_avg_blue,
    output logic [rbd_pkg::CH_W-1:0]     m_avg_alpha,
    output logic [rbd_pkg::RES_W-1:0]    m_result_width,
    output logic [rbd_pkg::RES_W-1:0]    m_result_height,
    output logic                         m_frame_done
);
    import rbd_pkg::*;

    localparam int COL_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int DVD_W = 2 * DIM_W + 1;
    localparam int CB_W  = $clog2(DIM_W);
    localparam int MB_W  = $clog2(CH_W);
    localparam logic [DIM_W-1:0] MAX_SRC = DIM_W'(MAX_SRC_DIM);
    localparam logic [DIM_W-1:0] MAX_OUT = DIM_W'(MAX_OUT_WIDTH);
    localparam logic [DIM_W-1:0] ONE     = DIM_W'(1);

    // sequencer codes
    localparam logic [3:0] S_CLAMP = 4'd0;
    localparam logic [3:0] S_SCALE = 4'd1;
    localparam logic [3:0] S_WPREP = 4'd2;
    localparam logic [3:0] S_WDIV  = 4'd3;
    localparam logic [3:0] S_HPREP = 4'd4;
    localparam logic [3:0] S_HDIV  = 4'd5;
    localparam logic [3:0] S_IDLE  = 4'd6;
    localparam logic [3:0] S_READ  = 4'd7;
    localparam logic [3:0] S_UPD   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]        state_reg;
    logic [SRC_CW-1:0] src_w_cfg_reg, src_h_cfg_reg;
    logic [LIM_CW-1:0] lim_w_cfg_reg, lim_h_cfg_reg;
    logic [DIM_W-1:0]  sw_reg, sh_reg, lw_reg, lh_reg;
    logic [DIM_W-1:0]  num_reg, den_reg, out_w_reg, out_h_reg;
    logic [DVD_W-1:0]  cdvd_reg;
    logic [DIM_W-1:0]  cq_reg;
    logic [CB_W-1:0]   cbit_reg;
    logic [DIM_W-1:0]  x_reg, y_reg, cacc_reg, racc_reg, oc_reg;
    logic              first_col_reg, first_row_reg;
    logic [CH_W-1:0]   pr_reg, pg_reg, pb_reg, pa_reg;
    logic [COL_W-1:0]  addr_reg;
    logic              clr_reg, last_reg, fdone_reg;
    acc_t              mem [MAX_OUT_WIDTH];
    acc_t              rd_data_reg;
    acc_t              wdata;
    logic [SUM_W-1:0]  rem_reg [4];
    logic [CH_W-1:0]   q_reg [4];
    logic [CNT_W-1:0]  cnt_reg;
    logic [MB_W-1:0]   mbit_reg;
    logic              m_valid_reg;
    logic [CH_W-1:0]   m_r_reg, m_g_reg, m_b_reg, m_a_reg;
    logic [RES_W-1:0]  m_w_reg, m_h_reg;
    logic              m_fd_reg;

    // register clamps
    logic [DIM_W-1:0] sw_c, sh_c, lw_c, lh_c;
    always_comb begin
        sw_c = DIM_W'(src_w_cfg_reg);
        sh_c = DIM_W'(src_h_cfg_reg);
        lw_c = DIM_W'(lim_w_cfg_reg);
        lh_c = DIM_W'(lim_h_cfg_reg);
        if (sw_c == '0) sw_c = ONE; else if (sw_c > MAX_SRC) sw_c = MAX_SRC;
        if (sh_c == '0) sh_c = ONE; else if (sh_c > MAX_SRC) sh_c = MAX_SRC;
        if (lw_c == '0) lw_c = ONE; else if (lw_c > MAX_OUT) lw_c = MAX_OUT;
        if (lh_c == '0) lh_c = ONE; else if (lh_c > MAX_OUT) lh_c = MAX_OUT;
    end

    // scale selection
    logic             w_scaled, h_scaled;
    logic [DIM_W-1:0] n1, d1;
    logic [DVD_W-2:0] lhs_prod, rhs_prod;
    assign w_scaled = sw_reg > lw_reg;
    assign n1 = w_scaled ? lw_reg : ONE;
    assign d1 = w_scaled ? sw_reg : ONE;
    assign lhs_prod = n1 * sh_reg;
    assign rhs_prod = lh_reg * d1;
    assign h_scaled = lhs_prod > rhs_prod;

    // ceiling divide step for output size
    logic [DVD_W-1:0] cdiv_sub;
    logic             cdiv_take;
    assign cdiv_sub  = DVD_W'(den_reg) << cbit_reg;
    assign cdiv_take = cdvd_reg >= cdiv_sub;

    // raster position stepping
    logic [DIM_W:0] x_inc, y_inc, cacc_sum, racc_sum;
    logic           x_last, y_last, col_wrap, row_wrap;
    assign x_inc    = {1'b0, x_reg} + 1'b1;
    assign y_inc    = {1'b0, y_reg} + 1'b1;
    assign cacc_sum = {1'b0, cacc_reg} + {1'b0, out_w_reg};
    assign racc_sum = {1'b0, racc_reg} + {1'b0, out_h_reg};
    assign x_last   = x_inc >= {1'b0, sw_reg};
    assign y_last   = y_inc >= {1'b0, sh_reg};
    assign col_wrap = cacc_sum >= {1'b0, sw_reg};
    assign row_wrap = racc_sum >= {1'b0, sh_reg};

    // a pending register write takes the idle slot, so pixels wait for it
    logic s_acc, cfg_acc, cfg_hit, out_free;
    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = state_reg == S_IDLE;
    assign s_acc     = s_valid && s_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign cfg_hit   = (cfg_index == REG_SRC_W) || (cfg_index == REG_SRC_H) ||
                       (cfg_index == REG_LIM_W) || (cfg_index == REG_LIM_H);
    assign out_free  = !m_valid_reg || m_ready;

    // accumulate word
    always_comb begin
        wdata = clr_reg ? '0 : rd_data_reg;
        wdata.red   = wdata.red   + SUM_W'(pr_reg);
        wdata.green = wdata.green + SUM_W'(pg_reg);
        wdata.blue  = wdata.blue  + SUM_W'(pb_reg);
        wdata.alpha = wdata.alpha + SUM_W'(pa_reg);
        wdata.count = wdata.count + 1'b1;
    end

    // column accumulator memory
    always_ff @(posedge aclk) begin
        if (state_reg == S_UPD) begin
            mem[addr_reg] <= wdata;
        end
        rd_data_reg <= mem[addr_reg];
    end

    // mean division lanes, one quotient bit per cycle
    logic [SUM_W-1:0] msub;
    assign msub = SUM_W'(cnt_reg) << mbit_reg;
    always_ff @(posedge aclk) begin
        if (state_reg == S_UPD) begin
            rem_reg[0] <= wdata.red;
            rem_reg[1] <= wdata.green;
            rem_reg[2] <= wdata.blue;
            rem_reg[3] <= wdata.alpha;
            cnt_reg    <= wdata.count;
            for (int i = 0; i < 4; i++) q_reg[i] <= '0;
        end else if (state_reg == S_DIV) begin
            for (int i = 0; i < 4; i++) begin
                if (cnt_reg != '0 && rem_reg[i] >= msub) begin
                    rem_reg[i] <= rem_reg[i] - msub;
                    q_reg[i][mbit_reg] <= 1'b1;
                end
            end
        end
    end

    // sequencer and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLAMP;
            src_w_cfg_reg <= RST_SRC_W;
            src_h_cfg_reg <= RST_SRC_H;
            lim_w_cfg_reg <= RST_LIM_W;
            lim_h_cfg_reg <= RST_LIM_H;
            m_valid_reg   <= 1'b0;
            num_reg       <= ONE;
            den_reg       <= ONE;
        end else begin
            // the output stage reloads the result register itself
            if (m_valid_reg && m_ready && state_reg != S_OUT) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLAMP: begin
                    sw_reg <= sw_c;
                    sh_reg <= sh_c;
                    lw_reg <= lw_c;
                    lh_reg <= lh_c;
                    x_reg <= '0; y_reg <= '0;
                    cacc_reg <= '0; racc_reg <= '0; oc_reg <= '0;
                    first_col_reg <= 1'b1;
                    first_row_reg <= 1'b1;
                    state_reg <= S_SCALE;
                end
                S_SCALE: begin
                    num_reg   <= h_scaled ? lh_reg : n1;
                    den_reg   <= h_scaled ? sh_reg : d1;
                    state_reg <= S_WPREP;
                end
                S_WPREP, S_HPREP: begin
                    cdvd_reg <= DVD_W'((state_reg == S_WPREP ? sw_reg : sh_reg) * num_reg)
                              + DVD_W'(den_reg) - 1'b1;
                    cq_reg   <= '0;
                    cbit_reg <= CB_W'(DIM_W - 1);
                    state_reg <= (state_reg == S_WPREP) ? S_WDIV : S_HDIV;
                end
                S_WDIV, S_HDIV: begin
                    if (cdiv_take) begin
                        cdvd_reg <= cdvd_reg - cdiv_sub;
                        cq_reg[cbit_reg] <= 1'b1;
                    end
                    cbit_reg <= cbit_reg - 1'b1;
                    if (cbit_reg == '0) begin
                        if (state_reg == S_WDIV) begin
                            out_w_reg <= cq_reg | (DIM_W'(cdiv_take));
                            state_reg <= S_HPREP;
                        end else begin
                            out_h_reg <= cq_reg | (DIM_W'(cdiv_take));
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_IDLE: begin
                    if (cfg_acc) begin
                        case (cfg_index)
                            REG_SRC_W: src_w_cfg_reg <= cfg_data;
                            REG_SRC_H: src_h_cfg_reg <= cfg_data;
                            REG_LIM_W: lim_w_cfg_reg <= cfg_data[LIM_CW-1:0];
                            REG_LIM_H: lim_h_cfg_reg <= cfg_data[LIM_CW-1:0];
                            default: ;
                        endcase
                        if (cfg_hit) state_reg <= S_CLAMP;
                    end else if (s_acc) begin
                        pr_reg <= s_pix_red;
                        pg_reg <= s_pix_green;
                        pb_reg <= s_pix_blue;
                        pa_reg <= s_pix_alpha;
                        addr_reg  <= oc_reg[COL_W-1:0];
                        clr_reg   <= first_col_reg && first_row_reg;
                        last_reg  <= (x_last || col_wrap) && (y_last || row_wrap);
                        fdone_reg <= x_last && y_last;
                        if (x_last) begin
                            x_reg <= '0; cacc_reg <= '0; oc_reg <= '0;
                            first_col_reg <= 1'b1;
                            if (y_last) begin
                                y_reg <= '0; racc_reg <= '0;
                                first_row_reg <= 1'b1;
                            end else begin
                                y_reg <= y_inc[DIM_W-1:0];
                                racc_reg <= row_wrap ? DIM_W'(racc_sum - {1'b0, sh_reg})
                                                     : racc_sum[DIM_W-1:0];
                                first_row_reg <= row_wrap;
                            end
                        end else begin
                            x_reg <= x_inc[DIM_W-1:0];
                            cacc_reg <= col_wrap ? DIM_W'(cacc_sum - {1'b0, sw_reg})
                                                 : cacc_sum[DIM_W-1:0];
                            oc_reg <= oc_reg + DIM_W'(col_wrap);
                            first_col_reg <= col_wrap;
                        end
                        state_reg <= S_READ;
                    end
                end
                S_READ: state_reg <= S_UPD;
                S_UPD: begin
                    mbit_reg  <= MB_W'(CH_W - 1);
                    state_reg <= last_reg ? S_DIV : S_IDLE;
                end
                S_DIV: begin
                    mbit_reg <= mbit_reg - 1'b1;
                    if (mbit_reg == '0) state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_r_reg  <= q_reg[0];
                        m_g_reg  <= q_reg[1];
                        m_b_reg  <= q_reg[2];
                        m_a_reg  <= q_reg[3];
                        m_w_reg  <= out_w_reg[RES_W-1:0];
                        m_h_reg  <= out_h_reg[RES_W-1:0];
                        m_fd_reg <= fdone_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_CLAMP;
            endcase
        end
    end

    // result word
    assign m_valid         = m_valid_reg;
    assign m_avg_red       = m_r_reg;
    assign m_avg_green     = m_g_reg;
    assign m_avg_blue      = m_b_reg;
    assign m_avg_alpha     = m_a_reg;
    assign m_result_width  = m_w_reg;
    assign m_result_height = m_h_reg;
    assign m_frame_done    = m_fd_reg;

`ifndef SYNTHESIS
    // accepted pixel goes to the memory read
    a_accept_read: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_READ)
        else $error("pixel accept did not start a read");

    // register write to a known index starts a recompute and blocks pixels
    a_cfg_recompute: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready && cfg_hit |=> state_reg == S_CLAMP && !s_ready)
        else $error("register write did not start recompute");

    // last quotient bit leads to the output stage
    a_div_end: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV && mbit_reg == '0 |=> state_reg == S_OUT)
        else $error("mean division did not finish");

    // a computed output size is never zero
    a_size_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> out_w_reg != '0 && out_h_reg != '0)
        else $error("zero output size");
`endif

endmodule
